// ===== sv/stb_pkg.sv =====
// Package for the software timer bank: sizes, opcode and status codes,
// controller states and the structs passed between controller and datapath.
// No dependencies.
package stb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 16;

  localparam int OP_W   = 4;
  localparam int SLOT_W = 4;
  localparam int PORT_TIME_W = 32;
  localparam int REM_W  = 33;
  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 4'd0,
    OP_SET        = 4'd1,
    OP_PLAY       = 4'd2,
    OP_PAUSE      = 4'd3,
    OP_STOP       = 4'd4,
    OP_RESET      = 4'd5,
    OP_RESTART    = 4'd6,
    OP_SET_REPEAT = 4'd7,
    OP_QUERY      = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_TIMER = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_EV,
    S_TICK_FLUSH,
    S_CMD_RD,
    S_CMD_EX
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic                 fired;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] duration;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic             use_idx;
    logic             tick_ev;
    logic             flush;
    logic             cmd_ex;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_unknown;
    logic ev_stall;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/stb_ctrl.sv =====
// Controller for the software timer bank: sequences input load, the per-slot
// tick sweep and single-slot commands. Depends on stb_pkg.
module stb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stb_pkg::dp_stat_t  stat_i,
  output stb_pkg::ctrl_cmd_t cmd_o
);
  import stb_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             idx_last;

  assign idx_last = (idx_q == IDX_W'(NUM_TIMERS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        idx_d = '0;
        if (stat_i.is_tick)         state_d = S_TICK_RD;
        else if (stat_i.is_unknown) state_d = S_IDLE;
        else                        state_d = S_CMD_RD;
      end
      S_TICK_RD: begin
        state_d = S_TICK_EV;
      end
      S_TICK_EV: begin
        if (!stat_i.ev_stall) begin
          if (idx_last) begin
            state_d = S_TICK_FLUSH;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_TICK_RD;
          end
        end
      end
      S_TICK_FLUSH: begin
        if (!stat_i.pend_valid) state_d = S_IDLE;
      end
      S_CMD_RD: begin
        state_d = S_CMD_EX;
      end
      S_CMD_EX: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: ;
      S_TICK_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.use_idx = 1'b1;
      end
      S_TICK_EV: begin
        cmd_o.use_idx = 1'b1;
        cmd_o.tick_ev = !stat_i.ev_stall;
      end
      S_TICK_FLUSH: begin
        cmd_o.flush = 1'b1;
      end
      S_CMD_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_CMD_EX: begin
        cmd_o.cmd_ex = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/stb_datapath.sv =====
// Datapath for the software timer bank: slot flags, elapsed and duration
// memories, fire/command evaluation, pending and output result registers.
// Depends on stb_pkg.
module stb_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  stb_pkg::ctrl_cmd_t                   cmd_i,
  output stb_pkg::dp_stat_t                    stat_o,
  input  logic [stb_pkg::OP_W-1:0]             opcode_i,
  input  logic [stb_pkg::SLOT_W-1:0]           slot_i,
  input  logic [stb_pkg::PORT_TIME_W-1:0]      time_value_i,
  input  logic                                 repeat_flag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [stb_pkg::SLOT_W-1:0]           slot_out_o,
  output logic                                 fired_o,
  output logic [stb_pkg::PORT_TIME_W-1:0]      elapsed_out_o,
  output logic [stb_pkg::PORT_TIME_W-1:0]      duration_out_o,
  output logic signed [stb_pkg::REM_W-1:0]     remaining_out_o,
  output logic                                 last_o
);
  import stb_pkg::*;

  // latched item
  logic [OP_W-1:0]      op_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_BITS-1:0] tv_q;
  logic                 rep_q;

  logic [NUM_TIMERS-1:0] valid_q, playing_q, repeat_q;

  logic [TIME_BITS-1:0] el_mem  [NUM_TIMERS];
  logic [TIME_BITS-1:0] dur_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0] rd_el_q, rd_dur_q;

  res_t             pend_q, out_q, pend_d, out_d;
  logic             pend_valid_q, out_valid_q;
  logic [CNT_W-1:0] cnt_q;

  logic [IDX_W-1:0]   slot_idx, rd_addr, wr_addr, flag_addr, free_idx;
  logic               slot_hit, free_found, out_free;
  logic [TIME_BITS:0] sum;
  logic [TIME_BITS-1:0] e_sat, wr_el, wr_dur;
  logic               fire, report, ev_stall;
  logic               el_we, dur_we, flag_we, valid_nx, playing_nx, repeat_nx;
  logic               pend_ld, pend_clr, out_ld;

  assign slot_idx = IDX_W'(slot_q);
  assign slot_hit = (32'(slot_q) < NUM_TIMERS) && valid_q[slot_idx];
  assign rd_addr  = cmd_i.use_idx ? cmd_i.idx : slot_idx;
  assign out_free = !out_valid_q || out_ready_i;

  assign sum    = {1'b0, rd_el_q} + {1'b0, tv_q};
  assign e_sat  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign fire   = valid_q[cmd_i.idx] && playing_q[cmd_i.idx] && (e_sat >= rd_dur_q);
  assign report = fire && (cnt_q < CNT_W'(MAX_RESULTS));
  assign ev_stall = report && pend_valid_q && !out_free;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    el_we      = 1'b0;
    dur_we     = 1'b0;
    wr_addr    = cmd_i.idx;
    wr_el      = '0;
    wr_dur     = tv_q;
    flag_we    = 1'b0;
    flag_addr  = slot_idx;
    valid_nx   = valid_q[slot_idx];
    playing_nx = playing_q[slot_idx];
    repeat_nx  = repeat_q[slot_idx];
    pend_ld    = 1'b0;
    pend_clr   = 1'b0;
    out_ld     = 1'b0;
    pend_d     = pend_q;
    out_d      = pend_q;

    if (cmd_i.tick_ev) begin
      if (valid_q[cmd_i.idx]) begin
        el_we = 1'b1;
        wr_el = (fire && repeat_q[cmd_i.idx]) ? '0 : e_sat;
        if (fire && !repeat_q[cmd_i.idx]) begin
          flag_we    = 1'b1;
          flag_addr  = cmd_i.idx;
          valid_nx   = 1'b0;
          playing_nx = playing_q[cmd_i.idx];
          repeat_nx  = repeat_q[cmd_i.idx];
        end
      end
      if (report) begin
        pend_ld         = 1'b1;
        pend_d.status   = ST_OK;
        pend_d.slot     = SLOT_W'(cmd_i.idx);
        pend_d.fired    = 1'b1;
        pend_d.elapsed  = repeat_q[cmd_i.idx] ? '0 : e_sat;
        pend_d.duration = rd_dur_q;
        pend_d.last     = 1'b0;
        out_ld          = pend_valid_q;
      end
    end

    if (cmd_i.flush && pend_valid_q && out_free) begin
      out_ld     = 1'b1;
      out_d.last = 1'b1;
      pend_clr   = 1'b1;
    end

    if (cmd_i.cmd_ex) begin
      out_ld         = 1'b1;
      out_d.status   = ST_OK;
      out_d.slot     = slot_q;
      out_d.fired    = 1'b0;
      out_d.elapsed  = rd_el_q;
      out_d.duration = rd_dur_q;
      out_d.last     = 1'b1;
      if (op_q == OP_SET) begin
        if (free_found) begin
          flag_we        = 1'b1;
          flag_addr      = free_idx;
          valid_nx       = 1'b1;
          playing_nx     = 1'b1;
          repeat_nx      = rep_q;
          el_we          = 1'b1;
          dur_we         = 1'b1;
          wr_addr        = free_idx;
          out_d.slot     = SLOT_W'(free_idx);
          out_d.elapsed  = '0;
          out_d.duration = tv_q;
        end else begin
          out_d.status   = ST_FULL;
          out_d.slot     = '0;
          out_d.elapsed  = '0;
          out_d.duration = '0;
        end
      end else if (!slot_hit) begin
        out_d.status   = ST_NO_TIMER;
        out_d.elapsed  = '0;
        out_d.duration = '0;
      end else begin
        wr_addr = slot_idx;
        unique case (op_q)
          OP_PLAY: begin
            flag_we    = 1'b1;
            playing_nx = 1'b1;
          end
          OP_PAUSE: begin
            flag_we    = 1'b1;
            playing_nx = 1'b0;
          end
          OP_STOP: begin
            flag_we  = 1'b1;
            valid_nx = 1'b0;
          end
          OP_RESET: begin
            el_we         = 1'b1;
            out_d.elapsed = '0;
          end
          OP_RESTART: begin
            el_we          = 1'b1;
            dur_we         = 1'b1;
            out_d.elapsed  = '0;
            out_d.duration = tv_q;
          end
          OP_SET_REPEAT: begin
            flag_we   = 1'b1;
            repeat_nx = rep_q;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      slot_q <= slot_i;
      tv_q   <= TIME_BITS'(time_value_i);
      rep_q  <= repeat_flag_i;
    end
    if (cmd_i.rd_en) begin
      rd_el_q  <= el_mem[rd_addr];
      rd_dur_q <= dur_mem[rd_addr];
    end
    if (el_we)   el_mem[wr_addr]  <= wr_el;
    if (dur_we)  dur_mem[wr_addr] <= wr_dur;
    if (pend_ld) pend_q <= pend_d;
    if (out_ld)  out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      playing_q    <= '0;
      repeat_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (flag_we) begin
        valid_q[flag_addr]   <= valid_nx;
        playing_q[flag_addr] <= playing_nx;
        repeat_q[flag_addr]  <= repeat_nx;
      end
      if (cmd_i.load)   cnt_q <= '0;
      else if (pend_ld) cnt_q <= cnt_q + CNT_W'(1);
      if (pend_ld)       pend_valid_q <= 1'b1;
      else if (pend_clr) pend_valid_q <= 1'b0;
      if (out_ld)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.is_tick    = (op_q == OP_TICK);
  assign stat_o.is_unknown = (op_q > OP_QUERY);
  assign stat_o.ev_stall   = ev_stall;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = out_free;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign slot_out_o      = out_q.slot;
  assign fired_o         = out_q.fired;
  assign elapsed_out_o   = PORT_TIME_W'(out_q.elapsed);
  assign duration_out_o  = PORT_TIME_W'(out_q.duration);
  assign remaining_out_o = REM_W'(out_q.duration) - REM_W'(out_q.elapsed);
  assign last_o          = out_q.last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("report count beyond limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> out_free)
    else $error("result register overwritten while stalled");

  a_pend_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd_ex |-> !pend_valid_q)
    else $error("pending fire result left over during command");

endmodule

// ===== sv/software_timer_bank.sv =====
// Software timer bank, top level: NUM_TIMERS slots, each with valid, playing
// and repeat flags, an elapsed time and a duration.
// Input channel (in_valid_i/in_ready_o) takes one tick or command per transfer.
// Output channel (out_valid_o/out_ready_i) returns results; last_o marks the
// final result of an item. A tick gives one result per fired slot (at most
// MAX_RESULTS) and none when nothing fires; a command gives exactly one, an unknown opcode none.
// Timing: a command passes through the decode, read and execute states, loads the
// result register in the execute state once the output register is free, and then
// returns to idle to take the next item. A tick sweeps the slots one at a time
// through a read state and an evaluate state; the elapsed and duration memories
// have a single read address. A new item is taken when the previous one has placed
// all its results, even while a result is still waiting.
// Stall: a fire result is held in a pending register until the next fire or
// the end of the sweep decides last_o; the sweep pauses only when both that
// register and the output register are full.
// Reset: all slots free, no result pending, output valid low.
// Depends on stb_pkg, stb_ctrl, stb_datapath.
module software_timer_bank (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [stb_pkg::OP_W-1:0]             opcode_i,
  input  logic [stb_pkg::SLOT_W-1:0]           slot_i,
  input  logic [stb_pkg::PORT_TIME_W-1:0]      time_value_i,
  input  logic                                 repeat_flag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [stb_pkg::SLOT_W-1:0]           slot_out_o,
  output logic                                 fired_o,
  output logic [stb_pkg::PORT_TIME_W-1:0]      elapsed_out_o,
  output logic [stb_pkg::PORT_TIME_W-1:0]      duration_out_o,
  output logic signed [stb_pkg::REM_W-1:0]     remaining_out_o,
  output logic                                 last_o
);
  import stb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stb_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .slot_i          (slot_i),
    .time_value_i    (time_value_i),
    .repeat_flag_i   (repeat_flag_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_out_o      (slot_out_o),
    .fired_o         (fired_o),
    .elapsed_out_o   (elapsed_out_o),
    .duration_out_o  (duration_out_o),
    .remaining_out_o (remaining_out_o),
    .last_o          (last_o)
  );

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.pend_valid)
    else $error("fire result still pending while idle");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> (status_o == ST_OK))
    else $error("fire result with error status");

  a_stall_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.ev_stall |-> (stat.pend_valid && !stat.out_free))
    else $error("sweep stalled without full result registers");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for software_timer_bank. A directed table runs first, then random ticks and commands.
// Results are checked against a timer-bank predictor in this file, or against typed table rows.
// Depends on stb_pkg and the software_timer_bank RTL.
module tb_top;
  import stb_pkg::*;

  localparam logic [OP_W-1:0] OP_FIRST_UNKNOWN = 4'd9;
  localparam logic [OP_W-1:0] OP_LAST_UNKNOWN  = 4'd15;
  localparam logic [PORT_TIME_W-1:0] TIME_MAX  = '1;
  localparam int RAND_PER_PHASE = 134;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 2 * NUM_TIMERS + 20;
  localparam int TX_IDLE_PCT [3] = '{38, 82, 0};
  localparam int RX_IDLE_PCT [3] = '{82, 38, 0};

  typedef struct packed {
    status_e                 status;
    logic [SLOT_W-1:0]       slot;
    logic                    fired;
    logic [PORT_TIME_W-1:0]  elapsed;
    logic [PORT_TIME_W-1:0]  duration;
    logic signed [REM_W-1:0] remaining;
    logic                    last;
  } timer_res_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SLOT_W-1:0]      slot;
    logic [PORT_TIME_W-1:0] tv;
    logic                   rep;
    logic [4:0]             count;
    logic                   typed;
    status_e                exp_status;
    logic [SLOT_W-1:0]      exp_slot;
    logic [PORT_TIME_W-1:0] exp_elapsed;
    logic [PORT_TIME_W-1:0] exp_duration;
  } dir_row_t;

  // op, slot, time, repeat, count, typed, status, slot, elapsed, duration
  localparam dir_row_t DIR_TAB [26] = '{
    '{OP_QUERY,      4'd0,  32'd0,       1'b0, 5'd1,  1'b1, ST_NO_TIMER, 4'd0,  32'd0, 32'd0},
    '{OP_PLAY,       4'd15, TIME_MAX,    1'b1, 5'd1,  1'b1, ST_NO_TIMER, 4'd15, 32'd0, 32'd0},
    '{OP_TICK,       4'd0,  32'd5,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_SET,        4'd0,  32'd0,       1'b0, 5'd1,  1'b1, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_SET,        4'd0,  TIME_MAX,    1'b1, 5'd1,  1'b1, ST_OK,       4'd1,  32'd0, TIME_MAX},
    '{OP_SET,        4'd0,  32'd10,      1'b1, 5'd1,  1'b1, ST_OK,       4'd2,  32'd0, 32'd10},
    '{OP_TICK,       4'd0,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_TICK,       4'd0,  TIME_MAX,    1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_PAUSE,      4'd2,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_PAUSE,      4'd1,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_TICK,       4'd0,  32'd7,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_TICK,       4'd0,  TIME_MAX,    1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_QUERY,      4'd2,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_PLAY,       4'd1,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_RESET,      4'd2,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_SET_REPEAT, 4'd2,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_PLAY,       4'd2,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_RESTART,    4'd2,  32'd3,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_TICK,       4'd0,  32'd3,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_STOP,       4'd1,  32'd0,       1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_STOP,       4'd1,  32'd0,       1'b0, 5'd1,  1'b1, ST_NO_TIMER, 4'd1,  32'd0, 32'd0},
    '{OP_LAST_UNKNOWN,  4'd15, TIME_MAX, 1'b1, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_FIRST_UNKNOWN, 4'd0,  32'd0,    1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_SET,        4'd0,  32'd1,       1'b0, 5'd16, 1'b0, ST_OK,       4'd0,  32'd0, 32'd0},
    '{OP_SET,        4'd0,  32'd9,       1'b1, 5'd1,  1'b1, ST_FULL,     4'd0,  32'd0, 32'd0},
    '{OP_TICK,       4'd0,  TIME_MAX,    1'b0, 5'd1,  1'b0, ST_OK,       4'd0,  32'd0, 32'd0}
  };

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic [OP_W-1:0]             opcode_i      = '0;
  logic [SLOT_W-1:0]           slot_i        = '0;
  logic [PORT_TIME_W-1:0]      time_value_i  = '0;
  logic                        repeat_flag_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic [1:0]                  status_o;
  logic [SLOT_W-1:0]           slot_out_o;
  logic                        fired_o;
  logic [PORT_TIME_W-1:0]      elapsed_out_o;
  logic [PORT_TIME_W-1:0]      duration_out_o;
  logic signed [REM_W-1:0]     remaining_out_o;
  logic                        last_o;

  // timer bank state as predicted
  bit                     tmr_valid    [NUM_TIMERS];
  bit                     tmr_playing  [NUM_TIMERS];
  bit                     tmr_repeat   [NUM_TIMERS];
  logic [PORT_TIME_W-1:0] tmr_elapsed  [NUM_TIMERS];
  logic [PORT_TIME_W-1:0] tmr_duration [NUM_TIMERS];

  timer_res_t pending_results [$];
  int         fail_count  = 0;
  int         rx_seen     = 0;
  int         hold_left   = 0;
  bit         hold_done   = 1'b0;
  int         tx_idle_pct = TX_IDLE_PCT[0];
  int         rx_idle_pct = RX_IDLE_PCT[0];

  software_timer_bank i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .time_value_i   (time_value_i),
    .repeat_flag_i  (repeat_flag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .fired_o        (fired_o),
    .elapsed_out_o  (elapsed_out_o),
    .duration_out_o (duration_out_o),
    .remaining_out_o(remaining_out_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic timer_res_t make_res(status_e st, logic [SLOT_W-1:0] s, logic f,
                                          logic [PORT_TIME_W-1:0] el,
                                          logic [PORT_TIME_W-1:0] dur);
    timer_res_t r;
    r.status    = st;
    r.slot      = s;
    r.fired     = f;
    r.elapsed   = el;
    r.duration  = dur;
    r.remaining = {1'b0, dur} - {1'b0, el};
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic predict_timer_results(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                       input logic [PORT_TIME_W-1:0] tv, input logic rep);
    logic [PORT_TIME_W:0]   sum;
    logic [PORT_TIME_W-1:0] fire_el;
    timer_res_t             held;
    bit                     have_held;
    int                     n;
    int                     free_idx;
    have_held = 1'b0;
    n         = 0;
    if (op == OP_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (tmr_valid[i]) begin
          sum = {1'b0, tmr_elapsed[i]} + {1'b0, tv};
          tmr_elapsed[i] = sum[PORT_TIME_W] ? TIME_MAX : sum[PORT_TIME_W-1:0];
          if (tmr_playing[i] && tmr_elapsed[i] >= tmr_duration[i]) begin
            fire_el = tmr_elapsed[i];
            if (tmr_repeat[i]) tmr_elapsed[i] = '0;
            else tmr_valid[i] = 1'b0;
            // results beyond the cap still update state but are not reported
            if (n < MAX_RESULTS) begin
              if (have_held) pending_results.push_back(held);
              held = make_res(ST_OK, SLOT_W'(i), 1'b1, tmr_repeat[i] ? '0 : fire_el,
                              tmr_duration[i]);
              have_held = 1'b1;
              n++;
            end
          end
        end
      end
    end else if (op == OP_SET) begin
      free_idx = -1;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
        if (!tmr_valid[i]) free_idx = i;
      end
      if (free_idx < 0) begin
        held = make_res(ST_FULL, '0, 1'b0, '0, '0);
      end else begin
        tmr_valid[free_idx]    = 1'b1;
        tmr_playing[free_idx]  = 1'b1;
        tmr_repeat[free_idx]   = rep;
        tmr_elapsed[free_idx]  = '0;
        tmr_duration[free_idx] = tv;
        held = make_res(ST_OK, SLOT_W'(free_idx), 1'b0, '0, tv);
      end
      have_held = 1'b1;
    end else if (op <= OP_QUERY) begin
      if (!tmr_valid[slot]) begin
        held = make_res(ST_NO_TIMER, slot, 1'b0, '0, '0);
      end else begin
        case (op)
          OP_PLAY:       tmr_playing[slot] = 1'b1;
          OP_PAUSE:      tmr_playing[slot] = 1'b0;
          OP_STOP:       tmr_valid[slot] = 1'b0;
          OP_RESET:      tmr_elapsed[slot] = '0;
          OP_RESTART: begin
            tmr_elapsed[slot]  = '0;
            tmr_duration[slot] = tv;
          end
          OP_SET_REPEAT: tmr_repeat[slot] = rep;
          default: ;
        endcase
        held = make_res(ST_OK, slot, 1'b0, tmr_elapsed[slot], tmr_duration[slot]);
      end
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_results.push_back(held);
    end
  endtask

  // called just after a rising edge; returns just after the edge of the transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [PORT_TIME_W-1:0] tv, input logic rep,
                           input logic typed, input timer_res_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    slot_i        <= slot;
    time_value_i  <= tv;
    repeat_flag_i <= rep;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_timer_results(op, slot, tv, rep);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_res);
    end
  endtask

  function automatic logic [PORT_TIME_W-1:0] pick_time(int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(span);
    if (r < 88) return $urandom_range(span * 50);
    if (r < 96) return $urandom;
    return r[0] ? TIME_MAX : '0;
  endfunction

  task automatic send_random(output bit counted);
    logic [OP_W-1:0]        op;
    logic [SLOT_W-1:0]      s;
    logic [PORT_TIME_W-1:0] tv;
    int unsigned            r;
    int                     live [$];
    timer_res_t             unused_res;
    r  = $urandom_range(99);
    tv = $urandom;
    s  = SLOT_W'($urandom_range(NUM_TIMERS - 1));
    unused_res = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (tmr_valid[i]) live.push_back(i);
    end
    if (r < 30) begin
      op = OP_TICK;
      tv = pick_time(30);
    end else if (r < 50) begin
      op = OP_SET;
      tv = pick_time(60);
    end else if (r < 96) begin
      op = OP_W'($urandom_range(int'(OP_PLAY), int'(OP_QUERY)));
      if (op == OP_RESTART) tv = pick_time(60);
      // mostly address live slots
      if (live.size() > 0 && $urandom_range(9) < 8) begin
        s = SLOT_W'(live[$urandom_range(live.size() - 1)]);
      end
    end else begin
      op = OP_W'($urandom_range(int'(OP_FIRST_UNKNOWN), int'(OP_LAST_UNKNOWN)));
    end
    counted = (op <= OP_QUERY);
    send_item(op, s, tv, 1'($urandom_range(1)), 1'b0, unused_res);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    timer_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: slot_out %0d status %0d", slot_out_o, status_o);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status",    exp_res.status,    status_o);
        check_field("slot_out",  exp_res.slot,      slot_out_o);
        check_field("fired",     exp_res.fired,     fired_o);
        check_field("elapsed",   exp_res.elapsed,   elapsed_out_o);
        check_field("duration",  exp_res.duration,  duration_out_o);
        check_field("remaining", exp_res.remaining, remaining_out_o);
        check_field("last",      exp_res.last,      last_o);
      end
    end
  end

  // receiver; one long hold-off so the bank backs up into the input
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    timer_res_t typed_res;
    int         accepted;
    bit         counted;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    foreach (DIR_TAB[r]) begin
      for (int k = 0; k < DIR_TAB[r].count; k++) begin
        typed_res = make_res(DIR_TAB[r].exp_status, DIR_TAB[r].exp_slot, 1'b0,
                             DIR_TAB[r].exp_elapsed, DIR_TAB[r].exp_duration);
        typed_res.last = 1'b1;
        send_item(DIR_TAB[r].op, DIR_TAB[r].slot, DIR_TAB[r].tv, DIR_TAB[r].rep,
                  DIR_TAB[r].typed, typed_res);
      end
    end
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = TX_IDLE_PCT[ph];
      rx_idle_pct = RX_IDLE_PCT[ph];
      accepted = 0;
      while (accepted < RAND_PER_PHASE) begin
        send_random(counted);
        if (counted) accepted++;
      end
      // sender pauses until the bank has drained
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (pending_results.size() != 0);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/stb_pkg.sv
sv/stb_ctrl.sv
sv/stb_datapath.sv
sv/software_timer_bank.sv
tb/sv/tb_top.sv
